// ----- hw/rtl/lpt_pkg.sv -----
// Shared types and constants for the lease presence tracker.
// No dependencies.
`default_nettype none
package lpt_pkg;
    localparam logic [1:0] KIND_LEASE  = 2'd0;
    localparam logic [1:0] KIND_DEPART = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic OP_LEASE = 1'b0;
    localparam logic OP_SWEEP = 1'b1;
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_LEASE = 1'b1;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] addr;
        logic        addr_known;
        logic [40:0] fs_time;
        logic        observed;
        logic [39:0] seen_time;
        logic [39:0] arrive_time;
        logic        present;
        logic [15:0] changes;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] device;
        logic        arrived;
        logic        readdressed;
        logic        newly_added;
        logic [40:0] fs_time;
        logic        fs_observed;
        logic [15:0] change_count;
        logic        last;
    } result_t;
endpackage
`default_nettype wire

// ----- hw/rtl/lease_presence_tracker.sv -----
// Lease presence tracker: inputs of a lease stream, outputs of device reports.
// Uses lpt_pkg and lpt_table.
//
// s_ channel takes one transaction: a lease or an end-of-poll sweep (tuser).
// m_ channel gives results; tuser is the kind, tlast marks the last result.
// A lease walks every table entry through the memory read port, comparing
// MACs and tracking a free slot and the oldest last-seen, then writes the
// entry back and gives its report.
// A full table re-reads the victim (S_EVREAD, S_EVWAIT); a present victim
// gives a departure first, held back while the receiver stalls.
// A sweep reads and checks each entry in turn (S_SWREAD, S_SWCHK), giving a
// departure for every valid, present, unseen entry, then the done result.
// One input is processed at a time; s_axis_tready is high only when idle.
// Reset clears valid and seen marks at once (flip-flop vectors) and the
// configuration registers; no clearing pass is needed.
// A receiver stall holds the result register and the walk pauses.
// Configuration through APB: register 0 first_poll_mode, 1 lease_time.
`default_nettype none
module lease_presence_tracker #(
    parameter int ENTRIES = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode
    input  wire logic         s_axis_tuser,
    // mac, ip_address, ip_known, expiry, now; zero fill to 168 bits
    input  wire logic [167:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // kind
    output logic [1:0]        m_axis_tuser,
    // device, arrived, readdressed, newly_added, first-seen time,
    // first-seen observed, change_count; zero fill to 112 bits
    output logic [111:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_EVREAD, S_EVWAIT, S_EVOUT, S_WRITE,
        S_SWREAD, S_SWCHK, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic mode_reg;
    logic [31:0] lease_reg;
    logic [ENTRIES-1:0] valid_reg, seen_reg;

    logic [47:0] mac_reg;
    logic [31:0] ip_reg;
    logic        ipk_reg;
    logic [39:0] exp_reg, now_reg;

    logic [CW-1:0] idx_reg;
    logic [AW-1:0] cmp_idx_reg;
    logic          cmp_v_reg;
    logic          hit_reg, free_reg;
    logic [AW-1:0] hit_idx_reg, free_idx_reg, old_idx_reg;
    logic [39:0]   old_ls_reg;
    logic          old_any_reg;
    logic [AW-1:0] slot_reg;
    lpt_pkg::entry_t ent_reg;
    logic          found_reg;

    logic [AW-1:0] rd_addr;
    lpt_pkg::entry_t rd_data;
    logic wr_en;
    lpt_pkg::entry_t wr_data;

    lpt_pkg::result_t res_reg;
    logic out_v_reg;

    lpt_table #(.ENTRIES(ENTRIES), .AW(AW)) u_table (
        .aclk(aclk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(slot_reg), .wr_data(wr_data)
    );

    assign pready = 1'b1;
    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == lpt_pkg::REG_LEASE) prdata = lease_reg;
        else prdata = {31'd0, mode_reg};
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {3'd0, res_reg.change_count, res_reg.fs_observed,
                            res_reg.fs_time, res_reg.newly_added,
                            res_reg.readdressed, res_reg.arrived,
                            res_reg.device};

    always_comb begin
        rd_addr = idx_reg[AW-1:0];
        if (state_reg == S_EVREAD) rd_addr = slot_reg;
    end

    // new-entry / update computation on the entry held in ent_reg
    logic [40:0] inf_fs;
    logic        readdr;
    lpt_pkg::entry_t upd;
    logic arrived_w;
    always_comb begin
        inf_fs = {1'b0, now_reg};
        if (lease_reg != 32'd0 && exp_reg != 40'd0)
            inf_fs = {1'b0, exp_reg} - {9'd0, lease_reg};
        if ($signed(inf_fs) > $signed({1'b0, now_reg})) inf_fs = {1'b0, now_reg};
        upd = ent_reg;
        readdr = 1'b0;
        arrived_w = 1'b0;
        if (found_reg) begin
            if (ent_reg.addr_known && (!ipk_reg || ent_reg.addr != ip_reg)) begin
                readdr = 1'b1;
                if (ent_reg.changes != 16'hFFFF) upd.changes = ent_reg.changes + 16'd1;
            end
            if (!ent_reg.present) begin
                arrived_w = 1'b1;
                upd.arrive_time = now_reg;
            end
        end else begin
            upd.mac = mac_reg;
            upd.changes = 16'd0;
            if (mode_reg) begin
                upd.fs_time = inf_fs;
                upd.observed = 1'b0;
                upd.arrive_time = 40'd0;
            end else begin
                upd.fs_time = {1'b0, now_reg};
                upd.observed = 1'b1;
                upd.arrive_time = now_reg;
                arrived_w = 1'b1;
            end
        end
        upd.present = 1'b1;
        upd.addr = ipk_reg ? ip_reg : 32'd0;
        upd.addr_known = ipk_reg;
        upd.seen_time = now_reg;
        wr_data = upd;
        wr_en = 1'b0;
        if (state_reg == S_WRITE && !out_v_reg) wr_en = 1'b1;
        // sweep write-back keeps the entry, clears presence of a departure
        if (state_reg == S_SWCHK) begin
            wr_data = rd_data;
            wr_data.present = 1'b0;
            wr_en = !out_v_reg && valid_reg[slot_reg] && !seen_reg[slot_reg]
                    && rd_data.present;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg <= 1'b0;
            lease_reg <= 32'd0;
            valid_reg <= '0;
            seen_reg <= '0;
            out_v_reg <= 1'b0;
            cmp_v_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == lpt_pkg::REG_LEASE) lease_reg <= pwdata;
                else mode_reg <= pwdata[0];
            end
            if (out_v_reg && m_axis_tready) out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        mac_reg <= s_axis_tdata[47:0];
                        ip_reg  <= s_axis_tdata[79:48];
                        ipk_reg <= s_axis_tdata[80];
                        exp_reg <= s_axis_tdata[120:81];
                        now_reg <= s_axis_tdata[160:121];
                        idx_reg <= '0;
                        cmp_v_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        old_any_reg <= 1'b0;
                        state_reg <= (s_axis_tuser == lpt_pkg::OP_SWEEP)
                                     ? S_SWREAD : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (cmp_v_reg && valid_reg[cmp_idx_reg]) begin
                        if (!hit_reg && rd_data.mac == mac_reg) begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= cmp_idx_reg;
                            ent_reg <= rd_data;
                        end
                        if (!old_any_reg || rd_data.seen_time < old_ls_reg) begin
                            old_any_reg <= 1'b1;
                            old_ls_reg <= rd_data.seen_time;
                            old_idx_reg <= cmp_idx_reg;
                        end
                    end
                    if (cmp_v_reg && !valid_reg[cmp_idx_reg] && !free_reg) begin
                        free_reg <= 1'b1;
                        free_idx_reg <= cmp_idx_reg;
                    end
                    cmp_idx_reg <= idx_reg[AW-1:0];
                    cmp_v_reg <= (idx_reg != CW'(ENTRIES));
                    if (idx_reg != CW'(ENTRIES)) idx_reg <= idx_reg + CW'(1);
                    else state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    found_reg <= hit_reg;
                    if (hit_reg) begin
                        slot_reg <= hit_idx_reg;
                        state_reg <= S_WRITE;
                    end else if (free_reg) begin
                        slot_reg <= free_idx_reg;
                        state_reg <= S_WRITE;
                    end else begin
                        slot_reg <= old_idx_reg;
                        state_reg <= S_EVREAD;
                    end
                end
                S_EVREAD: state_reg <= S_EVWAIT;
                S_EVWAIT: begin
                    ent_reg <= rd_data;
                    state_reg <= rd_data.present ? S_EVOUT : S_WRITE;
                end
                S_EVOUT: begin
                    if (!out_v_reg) begin
                        res_reg <= '{lpt_pkg::KIND_DEPART, ent_reg.mac, 1'b0, 1'b0,
                                     1'b0, ent_reg.fs_time, ent_reg.observed,
                                     ent_reg.changes, 1'b0};
                        out_v_reg <= 1'b1;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (!out_v_reg) begin
                        valid_reg[slot_reg] <= 1'b1;
                        seen_reg[slot_reg] <= 1'b1;
                        res_reg <= '{lpt_pkg::KIND_LEASE, mac_reg, arrived_w, readdr,
                                     !found_reg, upd.fs_time, upd.observed,
                                     upd.changes, 1'b1};
                        out_v_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_SWREAD: begin
                    slot_reg <= idx_reg[AW-1:0];
                    state_reg <= S_SWCHK;
                end
                S_SWCHK: begin
                    if (!out_v_reg) begin
                        if (valid_reg[slot_reg] && !seen_reg[slot_reg]
                            && rd_data.present) begin
                            res_reg <= '{lpt_pkg::KIND_DEPART, rd_data.mac, 1'b0,
                                         1'b0, 1'b0, rd_data.fs_time,
                                         rd_data.observed, rd_data.changes, 1'b0};
                            out_v_reg <= 1'b1;
                        end
                        seen_reg[slot_reg] <= 1'b0;
                        if (idx_reg == CW'(ENTRIES - 1)) state_reg <= S_DONE;
                        else begin
                            idx_reg <= idx_reg + CW'(1);
                            state_reg <= S_SWREAD;
                        end
                    end
                end
                S_DONE: begin
                    if (!out_v_reg) begin
                        res_reg <= '{lpt_pkg::KIND_DONE, 48'd0, 1'b0, 1'b0, 1'b0,
                                     41'd0, 1'b0, 16'd0, 1'b1};
                        out_v_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!out_v_reg || m_axis_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/lpt_table.sv -----
// Entry memory of the tracker: one synchronous read port, one write port.
// Depends on lpt_pkg.
`default_nettype none
module lpt_table #(
    parameter int ENTRIES = 32,
    parameter int AW = 5
) (
    input  wire logic            aclk,
    input  wire logic [AW-1:0]   rd_addr,
    output lpt_pkg::entry_t      rd_data,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire lpt_pkg::entry_t wr_data
);
    lpt_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- dv/lease_presence_tracker_test.sv -----
// Self-checking testbench for lease_presence_tracker: directed table, a first-poll fill
// past capacity, then random lease polls, results compared with an in-bench table model. Depends on lpt_pkg.
`timescale 1ns / 100ps
module lease_presence_tracker_test;
    localparam int NENT = 32;
    localparam int WDOG = 20000;

    typedef struct {
        logic        op;
        logic [47:0] mac;
        logic [31:0] ip;
        logic        ipk;
        logic [39:0] expiry;
        logic [39:0] now;
    } lease_t;

    typedef struct {
        lease_t           item;
        logic             chk;
        lpt_pkg::result_t res;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic s_axis_tuser = 0;
    logic [167:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [1:0] m_axis_tuser;
    logic [111:0] m_axis_tdata;
    logic m_axis_tlast;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    always #5 aclk = ~aclk;

    lease_presence_tracker dut (.*);

    // device table copy
    logic            cfg_mode;
    logic [31:0]     cfg_lease;
    logic            t_valid [NENT];
    logic            t_seen  [NENT];
    lpt_pkg::entry_t t_ent   [NENT];

    lpt_pkg::result_t expected_q[$];
    row_t dir_rows[$];
    int errors = 0;
    int idle_cycles = 0;
    int snd_idle = 0, rcv_idle = 0;
    logic [47:0] mac_pool [8];

    function automatic lpt_pkg::result_t mk(logic [1:0] k, logic [47:0] d, logic a,
                                            logic r, logic n, logic [40:0] fs, logic o,
                                            logic [15:0] c, logic l);
        lpt_pkg::result_t x;
        x.kind = k; x.device = d; x.arrived = a; x.readdressed = r; x.newly_added = n;
        x.fs_time = fs; x.fs_observed = o; x.change_count = c; x.last = l;
        return x;
    endfunction

    function automatic void queue_result(lpt_pkg::result_t x);
        expected_q.insert(expected_q.size(), x);
    endfunction

    function automatic void add_row(lease_t it, logic chk, lpt_pkg::result_t res);
        row_t r;
        r.item = it; r.chk = chk; r.res = res;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    task automatic track_lease(input lease_t it);
        int hit, slot;
        logic arr, rd, add;
        logic signed [42:0] fs;
        hit = -1; slot = -1; arr = 1'b0; rd = 1'b0; add = 1'b0;
        if (it.op == lpt_pkg::OP_SWEEP) begin
            for (int i = 0; i < NENT; i++) begin
                if (t_valid[i] && !t_seen[i] && t_ent[i].present) begin
                    queue_result(mk(lpt_pkg::KIND_DEPART, t_ent[i].mac, 1'b0, 1'b0, 1'b0,
                        t_ent[i].fs_time, t_ent[i].observed, t_ent[i].changes, 1'b0));
                    t_ent[i].present = 1'b0;
                end
                t_seen[i] = 1'b0;
            end
            queue_result(mk(lpt_pkg::KIND_DONE, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0, '0, 1'b1));
            return;
        end
        for (int i = 0; i < NENT; i++)
            if (hit < 0 && t_valid[i] && t_ent[i].mac == it.mac) hit = i;
        if (hit >= 0) begin
            slot = hit;
            if (t_ent[slot].addr_known && (!it.ipk || t_ent[slot].addr != it.ip)) begin
                rd = 1'b1;
                if (t_ent[slot].changes != 16'hFFFF) t_ent[slot].changes++;
            end
            if (!t_ent[slot].present) begin
                arr = 1'b1;
                t_ent[slot].arrive_time = it.now;
            end
        end else begin
            for (int i = 0; i < NENT; i++)
                if (slot < 0 && !t_valid[i]) slot = i;
            if (slot < 0) begin
                slot = 0;
                for (int i = 1; i < NENT; i++)
                    if (t_ent[i].seen_time < t_ent[slot].seen_time) slot = i;
                if (t_ent[slot].present)
                    queue_result(mk(lpt_pkg::KIND_DEPART, t_ent[slot].mac, 1'b0, 1'b0,
                        1'b0, t_ent[slot].fs_time, t_ent[slot].observed,
                        t_ent[slot].changes, 1'b0));
            end
            add = 1'b1;
            t_valid[slot] = 1'b1;
            t_ent[slot].mac = it.mac;
            t_ent[slot].changes = '0;
            if (cfg_mode) begin
                if (cfg_lease != 0 && it.expiry != 0)
                    fs = $signed({3'b0, it.expiry}) - $signed({11'b0, cfg_lease});
                else
                    fs = $signed({3'b0, it.now});
                if (fs > $signed({3'b0, it.now})) fs = $signed({3'b0, it.now});
                t_ent[slot].fs_time = fs[40:0];
                t_ent[slot].observed = 1'b0;
                t_ent[slot].arrive_time = '0;
            end else begin
                t_ent[slot].fs_time = {1'b0, it.now};
                t_ent[slot].observed = 1'b1;
                t_ent[slot].arrive_time = it.now;
                arr = 1'b1;
            end
        end
        t_ent[slot].present = 1'b1;
        t_seen[slot] = 1'b1;
        t_ent[slot].addr = it.ipk ? it.ip : '0;
        t_ent[slot].addr_known = it.ipk;
        t_ent[slot].seen_time = it.now;
        queue_result(mk(lpt_pkg::KIND_LEASE, it.mac, arr, rd, add, t_ent[slot].fs_time,
            t_ent[slot].observed, t_ent[slot].changes, 1'b1));
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == lpt_pkg::REG_MODE) cfg_mode = val[0];
        else cfg_lease = val;
    endtask

    // tvalid stays high into the next transaction unless the sender idles
    task automatic send_lease(input lease_t it);
        while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= it.op;
        s_axis_tdata <= {7'b0, it.now, it.expiry, it.ipk, it.ip, it.mac};
        do @(posedge aclk); while (!s_axis_tready);
        track_lease(it);
    endtask

    task automatic drain(input int quiet);
        s_axis_tvalid <= 0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (quiet) @(posedge aclk);
    endtask

    function automatic lease_t rand_lease();
        lease_t it;
        int r;
        r = $urandom_range(99);
        it.op = (r < 6) ? lpt_pkg::OP_SWEEP : lpt_pkg::OP_LEASE;
        it.mac = (r < 70) ? mac_pool[$urandom_range(7)] : 48'({$urandom, $urandom});
        it.ip = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
        it.ipk = ($urandom_range(4) != 0);
        it.expiry = ($urandom_range(5) == 0) ? 40'h0 : 40'({$urandom, $urandom});
        it.now = ($urandom_range(3) == 0) ? 40'({$urandom, $urandom})
                                          : 40'($urandom_range(200));
        return it;
    endfunction

    // result checker
    always @(posedge aclk) begin
        lpt_pkg::result_t got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = mk(m_axis_tuser, m_axis_tdata[47:0], m_axis_tdata[48],
                     m_axis_tdata[49], m_axis_tdata[50], m_axis_tdata[91:51],
                     m_axis_tdata[92], m_axis_tdata[108:93], m_axis_tlast);
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("result: expected %h actual %h", want, got);
                end
            end
        end
    end

    always @(posedge aclk)
        m_axis_tready <= (rcv_idle == 0) || ($urandom_range(99) >= rcv_idle);

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("lease_presence_tracker: mismatch");
            $finish;
        end
    end

    initial begin
        lease_t it;
        row_t row;
        lpt_pkg::result_t sent_exp;
        cfg_mode = 0; cfg_lease = 0;
        for (int i = 0; i < NENT; i++) begin
            t_valid[i] = 1'b0; t_seen[i] = 1'b0; t_ent[i] = '0;
        end
        for (int i = 0; i < 8; i++) mac_pool[i] = 48'({$urandom, $urandom});
        mac_pool[0] = '0; mac_pool[1] = '1;
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // directed: extremes, returns, address loss, sweeps
        it = '{lpt_pkg::OP_LEASE, 48'h0, 32'h0, 1'b1, 40'h0, 40'h0};
        add_row(it, 1'b1, mk(lpt_pkg::KIND_LEASE, 48'h0, 1'b1, 1'b0, 1'b1, '0, 1'b1, '0,
                             1'b1));
        it = '{lpt_pkg::OP_LEASE, '1, '1, 1'b1, '1, '1};
        add_row(it, 1'b1, mk(lpt_pkg::KIND_LEASE, '1, 1'b1, 1'b0, 1'b1,
                             {1'b0, 40'hFFFFFFFFFF}, 1'b1, '0, 1'b1));
        it = '{lpt_pkg::OP_LEASE, 48'h0, 32'h1, 1'b1, 40'h5, 40'h3};
        add_row(it, 1'b1, mk(lpt_pkg::KIND_LEASE, 48'h0, 1'b0, 1'b1, 1'b0, '0, 1'b1,
                             16'd1, 1'b1));
        it = '{lpt_pkg::OP_LEASE, 48'h0, 32'h1, 1'b0, 40'h5, 40'h4};
        add_row(it, 1'b0, '0);
        it = '{lpt_pkg::OP_LEASE, 48'h0, 32'h0, 1'b0, 40'h0, 40'h6};
        add_row(it, 1'b0, '0);
        it = '{lpt_pkg::OP_SWEEP, '1, '1, 1'b1, '1, '1};
        add_row(it, 1'b0, '0);
        it = '{lpt_pkg::OP_LEASE, 48'h0, 32'h7, 1'b1, 40'h0, 40'h9};
        add_row(it, 1'b0, '0);
        it = '{lpt_pkg::OP_SWEEP, '0, '0, 1'b0, '0, '0};
        add_row(it, 1'b0, '0);
        it = '{lpt_pkg::OP_LEASE, '1, '1, 1'b1, '1, 40'h10};
        add_row(it, 1'b0, '0);
        it = '{lpt_pkg::OP_SWEEP, '0, '0, 1'b0, '0, '0};
        add_row(it, 1'b0, '0);
        for (int i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            send_lease(row.item);
            if (row.chk) begin
                sent_exp = expected_q[expected_q.size() - 1];
                if (sent_exp !== row.res) begin
                    errors++;
                    if (errors <= 10) $display("row %0d: expected %h model %h", i, row.res,
                                               sent_exp);
                end
            end
        end
        drain(80);

        // first-poll mode, fill past capacity so entries get evicted
        apb_write(lpt_pkg::REG_MODE, 32'h1);
        apb_write(lpt_pkg::REG_LEASE, 32'hFFFFFFFF);
        for (int i = 0; i < 40; i++) begin
            it = '{lpt_pkg::OP_LEASE, 48'(i + 100), $urandom, 1'($urandom),
                   40'($urandom_range(3) * 64'h7FFFFFFF), 40'(i + 20)};
            send_lease(it);
        end
        send_lease('{lpt_pkg::OP_SWEEP, '0, '0, 1'b0, '0, '0});
        drain(80);

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = (ph == 0) ? 16 : (ph == 1) ? 50 : 0;
            rcv_idle = (ph == 0) ? 50 : (ph == 1) ? 16 : 0;
            apb_write(lpt_pkg::REG_MODE, 32'($urandom_range(1)));
            apb_write(lpt_pkg::REG_LEASE, (ph == 2) ? 32'h0 : $urandom);
            for (int i = 0; i < 140; i++) send_lease(rand_lease());
            send_lease('{lpt_pkg::OP_SWEEP, '0, '0, 1'b0, '0, '0});
            drain(80);
        end

        if (errors == 0)
            $display("lease_presence_tracker: match");
        else
            $display("lease_presence_tracker: mismatch");
        $finish;
    end
endmodule
